@@ hdl/sorted_min_priority_queue_macros.svh @@
// assertion macros for the sorted minimum priority queue
// used by the top level; expects clk and arst_n in scope
`ifndef SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_MACROS_SVH

// condition implies consequence in the same cycle
`define SMPQ_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("smpq check failed");

// condition implies consequence in the next cycle
`define SMPQ_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("smpq check failed");

`endif

@@ hdl/smpq_pkg.sv @@
// shared types and constants of the sorted minimum priority queue
// no dependencies
package smpq_pkg;

	localparam int DEPTH = 8;
	localparam int VAL_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_LIST   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	// per-cell control from the queue controller
	typedef struct packed {
		cell_op_t op;
		logic     occ;       // cell holds a value
		logic     at_count;  // first free cell
		logic     at_tail;   // last held cell
	} cell_ctl_t;

endpackage

@@ hdl/smpq_req_if.sv @@
// request channel: operation mode and value
// depends on smpq_pkg
interface smpq_req_if import smpq_pkg::*; ;
	logic  valid;
	logic  ready;
	mode_t mode;
	val_t  value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

@@ hdl/smpq_rsp_if.sv @@
// response channel: status, value and last marker
// depends on smpq_pkg
interface smpq_rsp_if import smpq_pkg::*; ;
	logic    valid;
	logic    ready;
	status_t status;
	val_t    result_value;
	logic    last;

	modport source (output valid, output status, output result_value, output last,
		input ready);
	modport sink (input valid, input status, input result_value, input last,
		output ready);
endinterface

@@ hdl/smpq_cell.sv @@
// one storage cell of the sorted chain: holds a value and compares it
// with the incoming value; depends on smpq_pkg
module smpq_cell import smpq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  val_t      new_value,
	input  logic      prev_gt,
	input  val_t      prev_value,
	input  val_t      next_value,
	input  val_t      head_value,
	output logic      gt,
	output val_t      value
);

	val_t value_q;

	// equal values stay put so a new value lands after them
	assign gt    = ctl.occ && (value_q > new_value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (prev_gt) begin
					value_q <= prev_value;
				end else if (gt || ctl.at_count) begin
					value_q <= new_value;
				end
			end
			CELL_ROTATE: begin
				// tail takes the old head, so a full rotation restores the order
				if (ctl.at_tail) begin
					value_q <= head_value;
				end else begin
					value_q <= next_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/sorted_min_priority_queue.sv @@
// Sorted minimum priority queue of DEPTH signed 32-bit values, kept in ascending order in a
// chain of cells. Insert, delete and peek each give one response: the cells compare the new value
// in parallel and shift in one step. List emits one held value per cycle while the output register
// is free, each held value once, by rotating the chain through its head cell; the next request
// is taken once the last listed value is in the output register. A request is taken only while
// the output register is free or its response leaves in the same cycle, so a waiting response
// stalls the request side. An empty queue answers delete, peek and list with status empty.
// depends on smpq_pkg, smpq_req_if, smpq_rsp_if, smpq_cell and the assertion macros
`include "sorted_min_priority_queue_macros.svh"

module sorted_min_priority_queue import smpq_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	smpq_req_if.sink  req,
	smpq_rsp_if.source rsp
);

	cnt_t    count_q;
	cnt_t    list_idx_q;
	logic    listing_q;
	logic    out_valid_q;
	status_t status_q;
	val_t    result_q;
	logic    last_q;

	logic      out_free;
	logic      take;
	logic      list_step;
	logic      empty;
	logic      full;
	cell_op_t  op;
	val_t      head;
	status_t   res_status;
	val_t      res_value;
	logic      res_last;

	cell_ctl_t ctl    [DEPTH];
	val_t      cell_val [DEPTH];
	logic      cell_gt  [DEPTH];
	logic      pgt      [DEPTH];
	val_t      pval     [DEPTH];
	val_t      nval     [DEPTH];

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = !listing_q && out_free;
	assign take      = req.valid && req.ready;
	assign list_step = listing_q && out_free;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head      = cell_val[0];

	always_comb begin
		op = CELL_HOLD;
		if (take) begin
			case (req.mode)
				MODE_INSERT: op = full ? CELL_HOLD : CELL_INSERT;
				MODE_DELETE: op = empty ? CELL_HOLD : CELL_ROTATE;
				MODE_LIST:   op = empty ? CELL_HOLD : CELL_ROTATE;
				default:     op = CELL_HOLD;
			endcase
		end else if (list_step) begin
			op = CELL_ROTATE;
		end
	end

	always_comb begin
		res_status = ST_OK;
		res_value  = '0;
		res_last   = 1'b1;
		if (list_step) begin
			res_value = head;
			res_last  = (list_idx_q == count_q - CNT_W'(1));
		end else if (req.mode == MODE_INSERT) begin
			res_status = full ? ST_FULL : ST_OK;
		end else if (empty) begin
			res_status = ST_EMPTY;
		end else begin
			res_value = head;
			res_last  = (req.mode != MODE_LIST) || (count_q == CNT_W'(1));
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i].op       = op;
		assign ctl[i].occ      = (CNT_W'(i) < count_q);
		assign ctl[i].at_count = (count_q == CNT_W'(i));
		assign ctl[i].at_tail  = (count_q == CNT_W'(i + 1));

		if (i == 0) begin : g_first
			assign pgt[i]  = 1'b0;
			assign pval[i] = cell_val[i];
		end else begin : g_mid
			assign pgt[i]  = cell_gt[i-1];
			assign pval[i] = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign nval[i] = cell_val[i];
		end else begin : g_inner
			assign nval[i] = cell_val[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.new_value  (req.value),
			.prev_gt    (pgt[i]),
			.prev_value (pval[i]),
			.next_value (nval[i]),
			.head_value (head),
			.gt         (cell_gt[i]),
			.value      (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			list_idx_q  <= '0;
			listing_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (req.mode == MODE_INSERT && !full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (req.mode == MODE_DELETE && !empty) begin
					count_q <= count_q - CNT_W'(1);
				end else if (req.mode == MODE_LIST && !empty && count_q != CNT_W'(1)) begin
					listing_q  <= 1'b1;
					list_idx_q <= CNT_W'(1);
				end
			end else if (list_step) begin
				list_idx_q <= list_idx_q + CNT_W'(1);
				if (res_last) begin
					listing_q <= 1'b0;
				end
			end
			if (take || list_step) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take || list_step) begin
			status_q <= res_status;
			result_q <= res_value;
			last_q   <= res_last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.result_value = result_q;
	assign rsp.last         = last_q;

	`SMPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`SMPQ_ASSERT_NOW(a_list_nonempty, listing_q, (count_q != '0) && (list_idx_q < count_q))
	`SMPQ_ASSERT_NEXT(a_insert_grows, take && req.mode == MODE_INSERT && !full, count_q == $past(count_q) + CNT_W'(1))
	`SMPQ_ASSERT_NEXT(a_list_keeps_count, list_step, count_q == $past(count_q))

endmodule

@@ tb/sorted_min_priority_queue_tb.sv @@
// self-checking testbench for the sorted minimum priority queue: random and directed
// operations, shadow sorted store for the expected responses, random stalls on both channels
// depends on smpq_pkg, smpq_req_if, smpq_rsp_if and sorted_min_priority_queue
module sorted_min_priority_queue_tb;
	import smpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_OPS  = 410;
	localparam int MAX_IDLE    = 11;

	typedef struct {
		mode_t mode;
		val_t  value;
		int    gap;
		bit    drain;
	} queue_op_t;

	typedef struct {
		status_t status;
		val_t    value;
		logic    last;
	} queue_rsp_t;

	logic clk;
	logic arst_n;

	smpq_req_if req_bus();
	smpq_rsp_if rsp_bus();

	sorted_min_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	queue_op_t  pending_ops[$];
	queue_rsp_t expected_rsp[$];

	// shadow copy of the sorted store
	val_t shadow_store[DEPTH];
	int   shadow_count = 0;

	int  mismatch_count = 0;
	bit  drv_calm = 1'b0;
	bit  rsp_calm = 1'b0;
	int  idle_left = -1;
	int  stall_left = 0;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	function automatic void push_rsp(status_t st, val_t v, logic lst);
		queue_rsp_t r;
		r.status = st;
		r.value  = v;
		r.last   = lst;
		expected_rsp.push_back(r);
	endfunction

	// advances the shadow store by one operation and queues its responses
	function automatic void apply_queue_op(mode_t m, val_t v);
		int   i;
		val_t head;
		if (m == MODE_INSERT) begin
			if (shadow_count >= DEPTH) begin
				push_rsp(ST_FULL, '0, 1'b1);
			end else begin
				// equal values keep arrival order: stop at the first entry not greater
				i = shadow_count;
				while (i > 0 && shadow_store[i-1] > v) begin
					shadow_store[i] = shadow_store[i-1];
					i--;
				end
				shadow_store[i] = v;
				shadow_count++;
				push_rsp(ST_OK, '0, 1'b1);
			end
		end else if (shadow_count == 0) begin
			push_rsp(ST_EMPTY, '0, 1'b1);
		end else if (m == MODE_DELETE) begin
			head = shadow_store[0];
			for (i = 0; i + 1 < shadow_count; i++)
				shadow_store[i] = shadow_store[i+1];
			shadow_count--;
			push_rsp(ST_OK, head, 1'b1);
		end else if (m == MODE_PEEK) begin
			push_rsp(ST_OK, shadow_store[0], 1'b1);
		end else begin
			for (i = 0; i < shadow_count; i++)
				push_rsp(ST_OK, shadow_store[i], (i + 1 == shadow_count));
		end
	endfunction

	function automatic void add_op(mode_t m, val_t v, bit drain);
		queue_op_t op;
		op.mode  = m;
		op.value = v;
		op.gap   = drv_calm ? 0 : $urandom_range(0, MAX_IDLE);
		op.drain = drain;
		pending_ops.push_back(op);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		queue_op_t next_op;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.mode  <= MODE_INSERT;
			req_bus.value <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready)
				apply_queue_op(req_bus.mode, req_bus.value);
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_ops.size() == 0) begin
					req_bus.valid <= 1'b0;
				end else if (pending_ops[0].drain && expected_rsp.size() != 0) begin
					req_bus.valid <= 1'b0;
				end else begin
					if (idle_left < 0)
						idle_left = pending_ops[0].gap;
					if (idle_left > 0) begin
						idle_left--;
						req_bus.valid <= 1'b0;
					end else begin
						next_op = pending_ops.pop_front();
						idle_left = -1;
						req_bus.valid <= 1'b1;
						req_bus.mode  <= next_op.mode;
						req_bus.value <= next_op.value;
					end
				end
			end
		end
	end

	// response monitor and checker
	always @(posedge clk or negedge arst_n) begin
		queue_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_rsp.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected transaction: status=%0d value=%0d last=%0b",
						$realtime, rsp_bus.status, rsp_bus.result_value, rsp_bus.last);
				end else begin
					exp_rsp = expected_rsp.pop_front();
					if (rsp_bus.status !== exp_rsp.status
						|| rsp_bus.result_value !== exp_rsp.value
						|| rsp_bus.last !== exp_rsp.last) begin
						mismatch_count++;
						$display("%0t: mismatch: expected status=%0d value=%0d last=%0b, got status=%0d value=%0d last=%0b",
							$realtime, exp_rsp.status, exp_rsp.value, exp_rsp.last,
							rsp_bus.status, rsp_bus.result_value, rsp_bus.last);
					end
				end
				if ($urandom_range(0, 63) == 0)
					rsp_calm = !rsp_calm;
				stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int   r;
		bit   fill_bias;
		val_t v;
		mode_t m;

		arst_n <= 1'b0;
		fill_bias = 1'b0;

		// empty queue on delete, peek and list
		add_op(MODE_DELETE, 32'h1234_5678, 1'b0);
		add_op(MODE_PEEK, 32'hffff_ffff, 1'b0);
		add_op(MODE_LIST, 32'h8000_0000, 1'b0);
		// fill with extremes and duplicates
		add_op(MODE_INSERT, 32'h7fff_ffff, 1'b0);
		add_op(MODE_INSERT, 32'h8000_0000, 1'b0);
		add_op(MODE_INSERT, 32'h0000_0000, 1'b0);
		add_op(MODE_INSERT, 32'hffff_ffff, 1'b0);
		add_op(MODE_INSERT, 32'h0000_0000, 1'b0);
		add_op(MODE_INSERT, 32'h0000_0001, 1'b0);
		add_op(MODE_INSERT, 32'h8000_0000, 1'b0);
		add_op(MODE_INSERT, 32'h7fff_ffff, 1'b0);
		// insert when full
		add_op(MODE_INSERT, 32'h0000_0003, 1'b0);
		add_op(MODE_LIST, 32'h0, 1'b0);
		add_op(MODE_PEEK, 32'h0, 1'b0);
		add_op(MODE_DELETE, 32'h0, 1'b0);
		add_op(MODE_DELETE, 32'h0, 1'b0);
		add_op(MODE_INSERT, 32'h5555_5555, 1'b0);
		add_op(MODE_INSERT, 32'haaaa_aaaa, 1'b0);
		add_op(MODE_INSERT, 32'haaaa_aaaa, 1'b0);
		add_op(MODE_LIST, 32'h0, 1'b0);

		for (int n = 0; n < RANDOM_OPS; n++) begin
			// alternate filling and draining phases so full and empty both recur
			if (n % 32 == 0)
				fill_bias = !fill_bias;
			if (n % 50 == 0)
				drv_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < (fill_bias ? 60 : 20))
				m = MODE_INSERT;
			else if (r < (fill_bias ? 70 : 65))
				m = MODE_DELETE;
			else if (r < (fill_bias ? 80 : 78))
				m = MODE_PEEK;
			else
				m = MODE_LIST;
			case ($urandom_range(0, 3))
				0: v = val_t'(int'($urandom_range(0, 8)) - 4);
				1: begin
					case ($urandom_range(0, 3))
						0: v = 32'h7fff_ffff;
						1: v = 32'h8000_0000;
						2: v = 32'h0;
						default: v = 32'hffff_ffff;
					endcase
				end
				default: v = $urandom;
			endcase
			add_op(m, v, (n == 0 || n == RANDOM_OPS / 2));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_bus.valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_req_if.sv
hdl/smpq_rsp_if.sv
hdl/smpq_cell.sv
hdl/sorted_min_priority_queue.sv
tb/sorted_min_priority_queue_tb.sv
